>>> hdl/iae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iae_pkg: shared types and constants of the immediate assignment encoder
// Message layout constants, frame-time divisors, the job descriptor that
// travels from the front end to the octet serializer, and the front FSM type.
// ----------------------------------------------------------------------------
package iae_pkg;

  localparam int BODY_BYTES_DEF = 22;
  localparam int FN_W           = 22;
  localparam int IDX_W          = 5;
  localparam int QDEPTH         = 2;

  localparam logic [7:0] LEN_OCTET = 8'h2D;
  localparam logic [7:0] FILLER    = 8'h2B;

  // fixed part and rest-octet field lengths in bits
  localparam int FIX_W  = 88;
  localparam int DL_W   = 74;
  localparam int DLNP_W = 58;
  localparam int UL_W   = 32;

  localparam int DIV_T1 = 26 * 51;
  localparam int DIV_T3 = 51;
  localparam int DIV_T2 = 26;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CALC,
    FR_DONE
  } fr_state_t;

  typedef struct packed {
    logic [4:0] t1;
    logic [5:0] t3;
    logic [4:0] t2;
  } ftime_t;

  typedef struct packed {
    logic        is_downlink;
    logic [7:0]  ra;
    logic [5:0]  ta;
    logic [9:0]  arfcn;
    logic [2:0]  ts;
    logic [2:0]  tsc;
    logic [4:0]  tfi;
    logic [2:0]  usf;
    logic [31:0] tlli;
    logic        poll;
    logic [1:0]  cs_code;
    ftime_t      fn_time;
    ftime_t      poll_time;
  } job_t;

endpackage
`default_nettype wire

>>> hdl/iae_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iae_front: request intake and frame-time derivation
// Captures a request, derives T1'/T3/T2 of both frame numbers by reciprocal
// multiplication, then hands a job to the queue.
// ----------------------------------------------------------------------------
module iae_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      in_is_downlink,
  input  wire logic [7:0]                in_random_access_ref,
  input  wire logic [iae_pkg::FN_W-1:0]  in_frame_number,
  input  wire logic [5:0]                in_timing_advance,
  input  wire logic [9:0]                in_arfcn,
  input  wire logic [2:0]                in_timeslot,
  input  wire logic [2:0]                in_training_seq,
  input  wire logic [4:0]                in_flow_id,
  input  wire logic [2:0]                in_uplink_state_flag,
  input  wire logic [31:0]               in_tlli,
  input  wire logic                      in_poll_request,
  input  wire logic [iae_pkg::FN_W-1:0]  in_poll_frame,
  input  wire logic [2:0]                cs,
  output logic                           q_push,
  output iae_pkg::job_t                  q_data,
  input  wire logic                      q_full
);
  import iae_pkg::*;

  localparam int CNT_W = 2;
  localparam int STEPS = 3;

  // exact reciprocals: ceil(2^SH / divisor) for the operand ranges used here
  localparam logic [22:0] RCP_T1 = 23'd6478081;  // 1326, any 22-bit frame number
  localparam int          SH_T1  = 33;
  localparam logic [11:0] RCP_T3 = 12'd2571;     // 51, remainder below 1326
  localparam int          SH_T3  = 17;
  localparam logic [11:0] RCP_T2 = 12'd2521;     // 26, remainder below 1326
  localparam int          SH_T2  = 16;

  typedef struct packed {
    logic [11:0] q1326;
    logic [10:0] r1326;
    logic [4:0]  q51;
    logic [5:0]  q26;
  } fdiv_t;

  // One pass of the three-stage chain; after three passes on a held frame
  // number every stage holds its final value.
  function automatic fdiv_t div_step(fdiv_t s, logic [FN_W-1:0] f);
    logic [44:0]     p1;
    logic [FN_W-1:0] m1;
    logic [22:0]     p3;
    logic [22:0]     p2;
    fdiv_t           n;
    p1      = 45'(f) * 45'(RCP_T1);
    n.q1326 = p1[SH_T1 +: 12];
    m1      = f - FN_W'(s.q1326) * FN_W'(DIV_T1);
    n.r1326 = m1[10:0];
    p3      = 23'(s.r1326) * 23'(RCP_T3);
    n.q51   = p3[SH_T3 +: 5];
    p2      = 23'(s.r1326) * 23'(RCP_T2);
    n.q26   = p2[SH_T2 +: 6];
    return n;
  endfunction

  function automatic ftime_t frame_time(fdiv_t s);
    logic [10:0] m3;
    logic [10:0] m2;
    ftime_t      t;
    m3   = s.r1326 - 11'(s.q51) * 11'(DIV_T3);
    m2   = s.r1326 - 11'(s.q26) * 11'(DIV_T2);
    t.t1 = s.q1326[4:0];
    t.t3 = m3[5:0];
    t.t2 = m2[4:0];
    return t;
  endfunction

  fr_state_t          st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [FN_W-1:0]    fn_r, pfn_r;
  fdiv_t              fdiv_r, pdiv_r;
  job_t               job_r;
  logic               accept;
  logic               step_en;

  assign accept = push && !full;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FR_IDLE: begin
        if (accept) st_nxt = FR_CALC;
      end
      FR_CALC: begin
        if (cnt_r == CNT_W'(STEPS - 1)) st_nxt = FR_DONE;
      end
      FR_DONE: begin
        if (!q_full) st_nxt = accept ? FR_CALC : FR_IDLE;
      end
      default: st_nxt = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full    = 1'b0;
    q_push  = 1'b0;
    step_en = 1'b0;
    unique case (st_r)
      FR_IDLE: begin
        full = 1'b0;
      end
      FR_CALC: begin
        full    = 1'b1;
        step_en = 1'b1;
      end
      FR_DONE: begin
        full   = q_full;
        q_push = !q_full;
      end
      default: full = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= FR_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (step_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fn_r                <= in_frame_number;
      pfn_r               <= in_poll_frame;
      fdiv_r              <= '0;
      pdiv_r              <= '0;
      job_r.is_downlink   <= in_is_downlink;
      job_r.ra            <= in_random_access_ref;
      job_r.ta            <= in_timing_advance;
      job_r.arfcn         <= in_arfcn;
      job_r.ts            <= in_timeslot;
      job_r.tsc           <= in_training_seq;
      job_r.tfi           <= in_flow_id;
      job_r.usf           <= in_uplink_state_flag;
      job_r.tlli          <= in_tlli;
      job_r.poll          <= in_poll_request;
      job_r.cs_code       <= 2'(cs - 3'd1);
      job_r.fn_time       <= '0;
      job_r.poll_time     <= '0;
    end else if (step_en) begin
      fdiv_r <= div_step(fdiv_r, fn_r);
      pdiv_r <= div_step(pdiv_r, pfn_r);
    end
  end

  always_comb begin
    q_data           = job_r;
    q_data.fn_time   = frame_time(fdiv_r);
    q_data.poll_time = frame_time(pdiv_r);
  end

endmodule
`default_nettype wire

>>> hdl/iae_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iae_fifo: job queue between front end and serializer
// Small register queue of job descriptors; lets either side stall alone.
// ----------------------------------------------------------------------------
module iae_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire iae_pkg::job_t  wdata,
  output logic                full,
  input  wire logic           pop,
  output iae_pkg::job_t       rdata,
  output logic                vld
);
  import iae_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t           mem_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign vld     = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && vld;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

>>> hdl/iae_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iae_back: message assembly and octet serializer
// Builds the message body of the current job over the filler pattern and
// sends the length octet and the body octets, one per transaction.
// ----------------------------------------------------------------------------
module iae_back #(
  parameter int BODY_BYTES = iae_pkg::BODY_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_vld,
  input  wire iae_pkg::job_t              q_data,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [7:0]                      out_byte_value,
  output logic [iae_pkg::IDX_W-1:0]       out_byte_index,
  output logic                            out_last
);
  import iae_pkg::*;

  localparam int BODY_W = BODY_BYTES * 8;
  localparam int REST_W = BODY_W - FIX_W;
  localparam int IW     = $clog2(BODY_BYTES + 1);
  localparam logic [BODY_W-1:0] FILL = {BODY_BYTES{FILLER}};

  job_t               job_r;
  logic               job_vld_r;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               out_vld_r;
  logic [7:0]         out_byte_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_last_r;

  logic [FIX_W-1:0]   fixed;
  logic [REST_W-1:0]  rest_w, rest_mask, rest;
  logic [DL_W-1:0]    w;
  logic [6:0]         wlen;
  logic [BODY_W-1:0]  body;
  logic [7:0]         octs [BODY_BYTES + 1];
  logic               emit, at_last;

  // fixed part: header, TBF octet, channel description, request reference, TA, empty mobile allocation
  assign fixed = {4'h0, 4'h6, 8'h3F, 2'b00, job_r.is_downlink, 1'b1, 4'h0,
                  5'd1, job_r.ts, job_r.tsc, 3'b000, job_r.arfcn, job_r.ra,
                  job_r.fn_time, 2'b00, job_r.ta, 8'h00};

  // rest octets, left justified
  always_comb begin
    if (job_r.is_downlink) begin
      if (job_r.poll) begin
        w    = {2'b11, 2'b01, job_r.tlli, 1'b1, job_r.tfi, 2'b00, 5'd0,
                1'b1, 1'b0, 1'b1, 4'h0, 1'b1, job_r.poll_time, 1'b0};
        wlen = 7'(DL_W);
      end else begin
        w    = {2'b11, 2'b01, job_r.tlli, 1'b1, job_r.tfi, 2'b00, 5'd0,
                1'b0, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, 16'h0};
        wlen = 7'(DLNP_W);
      end
    end else begin
      w    = {2'b11, 2'b00, 1'b1, job_r.tfi, 2'b00, job_r.usf, 2'b00,
              job_r.cs_code, 2'b11, 4'h0, 5'd0, 2'b00, 42'h0};
      wlen = 7'(UL_W);
    end
  end

  always_comb begin
    rest_w                     = '0;
    rest_w[REST_W-1 -: DL_W]   = w;
    rest_mask                  = ~({REST_W{1'b1}} >> wlen);
    rest                       = (rest_w & rest_mask) | (FILL[REST_W-1:0] & ~rest_mask);
    body                       = {fixed, rest};
  end

  always_comb begin
    octs[0] = LEN_OCTET;
    for (int k = 1; k <= BODY_BYTES; k++) begin
      octs[k] = body[(BODY_BYTES - k) * 8 +: 8];
    end
  end

  assign at_last = (idx_r == IW'(BODY_BYTES));
  assign emit    = job_vld_r && (!out_vld_r || pop);
  assign q_pop   = q_vld && (!job_vld_r || (emit && at_last));
  assign idx_nxt = at_last ? '0 : idx_r + IW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        job_vld_r <= 1'b1;
      end else if (emit && at_last) begin
        job_vld_r <= 1'b0;
      end
      if (emit) idx_r <= idx_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
    if (emit) begin
      out_byte_r <= octs[idx_r];
      out_idx_r  <= IDX_W'(idx_r);
      out_last_r <= at_last;
    end
  end

  assign empty          = !out_vld_r;
  assign out_byte_value = out_byte_r;
  assign out_byte_index = out_idx_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_len_octet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_idx_r == '0) |-> out_byte_r == LEN_OCTET)
    else $error("first octet is not the length octet");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_last_r == (out_idx_r == IDX_W'(BODY_BYTES))))
    else $error("last flag out of place");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !at_last) |=> (job_vld_r && idx_r == $past(idx_r) + IW'(1)))
    else $error("job dropped mid-message");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && pop && !out_last_r) |=>
      (out_vld_r && out_idx_r == $past(out_idx_r) + IDX_W'(1)))
    else $error("octet sequence broken inside a message");
`endif

endmodule
`default_nettype wire

>>> hdl/immediate_assignment_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// immediate_assignment_encoder_core: TBF immediate assignment message encoder
// Turns one assignment request into a length octet plus BODY_BYTES body
// octets, delivered through a queue-style result port.
// ----------------------------------------------------------------------------
// Each request accepted on the input queue port (push/full) produces one
// message of 1 + BODY_BYTES octets on the result queue port (empty/pop): the
// length octet 0x2D first, then the body with byte_index counting up and last
// set on the final octet. The body is the 0x2B filler with the fixed part
// (header, TBF octet, packet channel description, request reference with
// T1'/T3/T2 of the frame number, timing advance, empty mobile allocation) and
// either downlink or uplink rest octets written over it MSB first. Sustained
// throughput is set by the result port, one octet per cycle while pop is held;
// the front end derives the frame times by reciprocal multiplication, then
// hands the job off, and it overlaps the serialization of the previous
// message through a two-entry job queue. A request passes the front end's
// calculation and hand-off states, the job queue, the serializer's job
// register and the output register before its first octet appears. The
// coding scheme register (valid/ready, always ready) is sampled when a
// request is accepted; write it while idle.
// ----------------------------------------------------------------------------
module immediate_assignment_encoder_core #(
  parameter int BODY_BYTES = iae_pkg::BODY_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // request transactions
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      in_is_downlink,
  input  wire logic [7:0]                in_random_access_ref,
  input  wire logic [iae_pkg::FN_W-1:0]  in_frame_number,
  input  wire logic [5:0]                in_timing_advance,
  input  wire logic [9:0]                in_arfcn,
  input  wire logic [2:0]                in_timeslot,
  input  wire logic [2:0]                in_training_seq,
  input  wire logic [4:0]                in_flow_id,
  input  wire logic [2:0]                in_uplink_state_flag,
  input  wire logic [31:0]               in_tlli,
  input  wire logic                      in_poll_request,
  input  wire logic [iae_pkg::FN_W-1:0]  in_poll_frame,
  // octet transactions
  output logic                           empty,
  input  wire logic                      pop,
  output logic [7:0]                     out_byte_value,
  output logic [iae_pkg::IDX_W-1:0]      out_byte_index,
  output logic                           out_last,
  // coding scheme register
  input  wire logic                      valid,
  output logic                           ready,
  input  wire logic [2:0]                cfg_initial_coding_scheme
);
  import iae_pkg::*;

  logic [2:0] cs_r;
  logic       q_push, q_full, q_vld, q_pop;
  job_t       q_wdata, q_rdata;

  // config write: always ready, one register
  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r <= 3'd1;
    end else if (valid && ready) begin
      cs_r <= cfg_initial_coding_scheme;
    end
  end

  // front end: accept, hold fields, derive frame times
  iae_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_is_downlink       (in_is_downlink),
    .in_random_access_ref (in_random_access_ref),
    .in_frame_number      (in_frame_number),
    .in_timing_advance    (in_timing_advance),
    .in_arfcn             (in_arfcn),
    .in_timeslot          (in_timeslot),
    .in_training_seq      (in_training_seq),
    .in_flow_id           (in_flow_id),
    .in_uplink_state_flag (in_uplink_state_flag),
    .in_tlli              (in_tlli),
    .in_poll_request      (in_poll_request),
    .in_poll_frame        (in_poll_frame),
    .cs                   (cs_r),
    .q_push               (q_push),
    .q_data               (q_wdata),
    .q_full               (q_full)
  );

  // decouple: jobs wait here while the serializer drains the previous one
  iae_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .vld   (q_vld)
  );

  // back end: assemble the message and advance one octet per transaction
  iae_back #(
    .BODY_BYTES (BODY_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_vld          (q_vld),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte_value (out_byte_value),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

>>> bench/immediate_assignment_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// immediate_assignment_encoder_core_tb: self-checking bench for the encoder
// Feeds uplink and downlink assignment requests through the push/full port,
// rebuilds every 23-octet message bit by bit in the bench, and compares each
// popped octet with it while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module immediate_assignment_encoder_core_tb;

  localparam int NBODY         = iae_pkg::BODY_BYTES_DEF;
  localparam int MSG_W         = 8 * NBODY;
  localparam int FIELD_W       = 162;      // fixed part plus longest rest octets
  localparam int WATCHDOG_MAX  = 4000;     // cycles without any transaction
  localparam int PHASE_ITEMS   = 51;
  localparam int NUM_PHASES    = 8;
  localparam int SETTLE_CYCLES = 40;       // well past the first-octet latency

  localparam logic [7:0] LENGTH_OCTET = 8'h2D;   // (11 << 2) | 1
  localparam logic [7:0] FILL_OCTET   = 8'h2B;
  localparam logic [21:0] FN_LAST     = 22'd2715647;
  localparam logic [21:0] FN_ALL_ONES = 22'h3FFFFF;

  // idling profiles of a phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic        is_dl;
    logic [7:0]  ra;
    logic [21:0] fn;
    logic [5:0]  ta;
    logic [9:0]  arfcn;
    logic [2:0]  ts;
    logic [2:0]  tsc;
    logic [4:0]  tfi;
    logic [2:0]  usf;
    logic [31:0] tlli;
    logic        poll;
    logic [21:0] pfn;
  } assign_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic [4:0] index;
    logic       is_last;
  } octet_t;

  // DUT ports
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  logic                    in_is_downlink = 1'b0;
  logic [7:0]              in_random_access_ref = '0;
  logic [iae_pkg::FN_W-1:0] in_frame_number = '0;
  logic [5:0]              in_timing_advance = '0;
  logic [9:0]              in_arfcn = '0;
  logic [2:0]              in_timeslot = '0;
  logic [2:0]              in_training_seq = '0;
  logic [4:0]              in_flow_id = '0;
  logic [2:0]              in_uplink_state_flag = '0;
  logic [31:0]             in_tlli = '0;
  logic                    in_poll_request = 1'b0;
  logic [iae_pkg::FN_W-1:0] in_poll_frame = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [7:0]              out_byte_value;
  logic [iae_pkg::IDX_W-1:0] out_byte_index;
  logic                    out_last;
  logic                    valid = 1'b0;
  logic                    ready;
  logic [2:0]              cfg_initial_coding_scheme = 3'd1;

  // bench state
  assign_req_t pending_reqs[$];
  octet_t      expected_octets[$];
  logic [2:0]  coding_scheme = 3'd1;     // bench copy of the register
  logic        req_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;
  int          error_count = 0;
  int          msg_count = 0;
  int          dl_count = 0;
  int          octet_count = 0;

  immediate_assignment_encoder_core dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .push                      (push),
    .full                      (full),
    .in_is_downlink            (in_is_downlink),
    .in_random_access_ref      (in_random_access_ref),
    .in_frame_number           (in_frame_number),
    .in_timing_advance         (in_timing_advance),
    .in_arfcn                  (in_arfcn),
    .in_timeslot               (in_timeslot),
    .in_training_seq           (in_training_seq),
    .in_flow_id                (in_flow_id),
    .in_uplink_state_flag      (in_uplink_state_flag),
    .in_tlli                   (in_tlli),
    .in_poll_request           (in_poll_request),
    .in_poll_frame             (in_poll_frame),
    .empty                     (empty),
    .pop                       (pop),
    .out_byte_value            (out_byte_value),
    .out_byte_index            (out_byte_index),
    .out_last                  (out_last),
    .valid                     (valid),
    .ready                     (ready),
    .cfg_initial_coding_scheme (cfg_initial_coding_scheme)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // T1' / T3 / T2 triple of a frame number, 16 bits MSB first
  function automatic logic [15:0] frame_time(input logic [21:0] fn);
    int unsigned f;
    f = fn;
    return {5'((f / (26 * 51)) % 32), 6'(f % 51), 5'(f % 26)};
  endfunction

  // Build the full message of one request and queue its octets.
  function automatic void encode_assignment(input assign_req_t r, input logic [2:0] cs);
    logic [87:0]        fixed_part;
    logic [55:0]        dl_head;
    logic [FIELD_W-1:0] fields;
    logic [MSG_W-1:0]   msg;
    int                 nbits;
    int                 i;
    octet_t             o;
    fixed_part = {4'h0, 4'h6, 8'h3F, 2'b00, r.is_dl, 1'b1, 4'h0,
                  5'd1, r.ts, r.tsc, 3'b000, r.arfcn,
                  r.ra, frame_time(r.fn), 2'b00, r.ta, 8'h00};
    dl_head = {2'd3, 2'd1, r.tlli, 1'b1, r.tfi, 2'b00, 5'd0,
               r.poll, ~r.poll, 1'b1, 4'h0};
    if (r.is_dl && r.poll) begin
      fields = {fixed_part, dl_head, 1'b1, frame_time(r.pfn), 1'b0};
      nbits  = 162;
    end else if (r.is_dl) begin
      fields = {fixed_part, dl_head, 2'b00, 16'h0};
      nbits  = 146;
    end else begin
      // coding scheme goes out as (value - 1) kept to two bits
      fields = {fixed_part, 2'd3, 2'd0, 1'b1, r.tfi, 2'b00, r.usf, 2'b00,
                2'(cs - 3'd1), 2'b11, 4'h0, 5'd0, 2'b00, 42'h0};
      nbits  = 120;
    end
    msg = {NBODY{FILL_OCTET}};
    for (i = 0; i < nbits; i++) begin
      // drop bits beyond the body
      if (i < MSG_W) msg[MSG_W-1-i] = fields[FIELD_W-1-i];
    end
    o.value   = LENGTH_OCTET;
    o.index   = 5'd0;
    o.is_last = 1'b0;
    expected_octets.push_back(o);
    for (i = 1; i <= NBODY; i++) begin
      o.value   = msg[MSG_W-1-8*(i-1) -: 8];
      o.index   = 5'(i);
      o.is_last = (i == NBODY);
      expected_octets.push_back(o);
    end
  endfunction

  function automatic logic [21:0] rand_frame();
    // mostly legal frame numbers, sometimes the whole 22-bit space
    if ($urandom_range(7, 0) == 0) return 22'($urandom);
    return 22'($urandom_range(2715647, 0));
  endfunction

  function automatic assign_req_t rand_req();
    assign_req_t r;
    r.is_dl = 1'($urandom);
    r.ra    = 8'($urandom);
    r.fn    = rand_frame();
    r.ta    = 6'($urandom);
    r.arfcn = 10'($urandom);
    r.ts    = 3'($urandom);
    r.tsc   = 3'($urandom);
    r.tfi   = 5'($urandom);
    r.usf   = 3'($urandom);
    r.tlli  = $urandom;
    r.poll  = 1'($urandom);
    r.pfn   = rand_frame();
    return r;
  endfunction

  // Driver: present the head of the pending queue, hold it until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !req_taken) begin
      // hold the current transaction
    end else if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
      push                 <= 1'b1;
      in_is_downlink       <= pending_reqs[0].is_dl;
      in_random_access_ref <= pending_reqs[0].ra;
      in_frame_number      <= pending_reqs[0].fn;
      in_timing_advance    <= pending_reqs[0].ta;
      in_arfcn             <= pending_reqs[0].arfcn;
      in_timeslot          <= pending_reqs[0].ts;
      in_training_seq      <= pending_reqs[0].tsc;
      in_flow_id           <= pending_reqs[0].tfi;
      in_uplink_state_flag <= pending_reqs[0].usf;
      in_tlli              <= pending_reqs[0].tlli;
      in_poll_request      <= pending_reqs[0].poll;
      in_poll_frame        <= pending_reqs[0].pfn;
    end else begin
      push <= 1'b0;
    end
  end

  // Receiver: stall pop at random according to the phase.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Request side: track register writes and accepted requests, predict octets.
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (rst_n) begin
      if (valid && ready) coding_scheme = cfg_initial_coding_scheme;
      if (push && !full) begin
        req_taken = 1'b1;
        encode_assignment(pending_reqs[0], coding_scheme);
        if (pending_reqs[0].is_dl) dl_count++;
        msg_count++;
        pending_reqs.pop_front();
      end
    end
  end

  // Monitor: check every popped octet against the oldest expectation.
  always @(posedge clk) begin
    octet_t want;
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (valid && ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (pop && !empty) begin
        octet_count++;
        if (expected_octets.size() == 0) begin
          $error("unexpected octet: value %0h index %0d last %0b",
                 out_byte_value, out_byte_index, out_last);
          error_count++;
        end else begin
          want = expected_octets.pop_front();
          if (out_byte_value !== want.value) begin
            $error("byte_value mismatch: expected %0h actual %0h", want.value, out_byte_value);
            error_count++;
          end
          if (out_byte_index !== want.index) begin
            $error("byte_index mismatch: expected %0d actual %0d", want.index, out_byte_index);
            error_count++;
          end
          if (out_last !== want.is_last) begin
            $error("last mismatch: expected %0b actual %0b", want.is_last, out_last);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: no transaction for too long ends the run.
  initial begin
    wait (quiet_cycles >= WATCHDOG_MAX);
    $display("immediate_assignment_encoder_core_tb failed");
    $finish;
  end

  // Write the coding scheme register; call only while the block is idle.
  task automatic write_coding_scheme(input logic [2:0] cs);
    @(negedge clk);
    valid                     <= 1'b1;
    cfg_initial_coding_scheme <= cs;
    do @(posedge clk); while (!ready);
    @(negedge clk);
    valid <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_reqs.size() == 0 && expected_octets.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  // Stimulus sequencer
  initial begin
    logic [2:0]  cs_plan[NUM_PHASES];
    assign_req_t r;
    int          p;
    int          n;
    idle_mode_t  mode;
    cs_plan = '{3'd4, 3'd0, 3'd5, 3'd7, 3'd2, 3'd3, 3'd6, 3'd1};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset coding scheme, no idling.
    r = '{1'b0, 8'h00, 22'h0, 6'h00, 10'h000, 3'd0, 3'd0, 5'd0, 3'd0, 32'h0, 1'b0, 22'h0};
    pending_reqs.push_back(r);                 // uplink, all fields low
    r.is_dl = 1'b1;
    pending_reqs.push_back(r);                 // downlink without polling, all low
    r.poll = 1'b1;
    pending_reqs.push_back(r);                 // downlink polling at frame zero
    r = '{1'b0, 8'hFF, FN_ALL_ONES, 6'h3F, 10'h3FF, 3'd7, 3'd7, 5'd31, 3'd7,
          32'hFFFF_FFFF, 1'b1, FN_ALL_ONES};
    pending_reqs.push_back(r);                 // uplink all high; tlli/poll ignored
    r.is_dl = 1'b1;
    pending_reqs.push_back(r);                 // downlink all high with polling
    r.poll = 1'b0;
    pending_reqs.push_back(r);                 // downlink all high but no polling, usf ignored
    r = '{1'b1, 8'hA5, FN_LAST, 6'h2A, 10'h2AA, 3'd5, 3'd2, 5'd21, 3'd5,
          32'hAAAA_AAAA, 1'b1, FN_LAST};
    pending_reqs.push_back(r);                 // last legal frame numbers
    r = '{1'b1, 8'h5A, 22'd1325, 6'h15, 10'h155, 3'd2, 3'd5, 5'd10, 3'd2,
          32'h5555_5555, 1'b1, 22'd1326};
    pending_reqs.push_back(r);                 // T1' step across 1326
    r.fn = 22'd51; r.pfn = 22'd50;
    pending_reqs.push_back(r);                 // T3 wrap
    r.fn = 22'd26; r.pfn = 22'd25;
    pending_reqs.push_back(r);                 // T2 wrap
    r.fn = 22'd42432; r.pfn = 22'd42431;
    pending_reqs.push_back(r);                 // T1' wraps past 31
    r.is_dl = 1'b0; r.usf = 3'd4;
    pending_reqs.push_back(r);
    r.fn = FN_LAST + 22'd1;
    pending_reqs.push_back(r);                 // frame number just out of range
    r.is_dl = 1'b1; r.poll = 1'b0; r.tlli = 32'h8000_0001;
    pending_reqs.push_back(r);
    wait_drained();

    // Random phases: sweep the register and the idling profiles.
    for (p = 0; p < NUM_PHASES; p++) begin
      write_coding_scheme(cs_plan[p]);
      mode = idle_mode_t'(p % 4);
      case (mode)
        IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default:       begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pending_reqs.push_back(rand_req());
        // once, hold off the sender until every queued octet has come out
        if (p == 1 && n == PHASE_ITEMS / 2) begin
          wait (pending_reqs.size() == 0 && expected_octets.size() == 0);
        end
      end
      wait_drained();
    end

    // Catch any stray octets after the last message.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d assignment requests (%0d downlink, %0d uplink), %0d octets popped",
             msg_count, dl_count, msg_count - dl_count, octet_count);
    $display("Coding scheme values 0..7 swept under no idling, sender gaps, pop stalls, both");
    if (error_count == 0 && expected_octets.size() == 0) begin
      $display("immediate_assignment_encoder_core_tb passed");
    end else begin
      $display("immediate_assignment_encoder_core_tb failed");
    end
    $finish;
  end

endmodule
